>>> hdl/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg: shared types and constants for the postfix evaluator
// Stack geometry, character codes and the stack cell operation codes.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SYMBOL_W    = 8;
  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DIV_CNT_W   = $clog2(WORD_W);

  localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [SYMBOL_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'd43;
  localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [SYMBOL_W-1:0] CHAR_STAR  = 8'd42;
  localparam logic [SYMBOL_W-1:0] CHAR_SLASH = 8'd47;

  // read value of a pop from an empty stack, and the empty-stack result
  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  // what every stack cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,         // keep
    CELL_PUSH,         // take from the cell above (top takes the new word)
    CELL_POP_REPLACE,  // take from the cell below (top takes the new word)
    CELL_POP2          // take from two cells below
  } cell_op_t;

  function automatic logic is_digit(input logic [SYMBOL_W-1:0] sym);
    return (sym >= CHAR_ZERO) && (sym <= CHAR_NINE);
  endfunction

endpackage

>>> hdl/ppe_channels.sv
// ----------------------------------------------------------------------------
// ppe channels: valid/ready handshake interfaces
// Input byte channel and result channel of the postfix evaluator.
// ----------------------------------------------------------------------------
interface ppe_item_if
  import ppe_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                is_last;

  modport source (output valid, output symbol, output is_last, input ready);
  modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

interface ppe_result_if
  import ppe_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] result_value;
  logic                     underflow_seen;
  logic                     overflow_seen;
  logic                     divide_by_zero_seen;

  modport source (output valid, output result_value, output underflow_seen,
                  output overflow_seen, output divide_by_zero_seen, input ready);
  modport sink   (input valid, input result_value, input underflow_seen,
                  input overflow_seen, input divide_by_zero_seen, output ready);
endinterface

>>> hdl/postfix_expression_evaluator.sv
// Steps: a digit or non-operator byte goes IDLE, EXEC, FINISH; + - * go
// IDLE, EXEC, APPLY, FINISH; / by nonzero adds DIV_WAIT (32-step divider).
// Flow: one byte at a time, taken only in IDLE; a result waits in
// the output register while the next byte is already taken.
// Reset (rst, synchronous): empty stack, flags clear, no result pending;
// stack words themselves are not cleared.
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: RPN evaluator over a shifting cell stack
// Digits push, + - * / pop two and push one, other bytes pop two. The stack
// is a row of cells; the top lives in cell 0 and all cells move together.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator
  import ppe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ppe_item_if.sink     item,
  ppe_result_if.source result
);

  typedef enum logic [2:0] {
    ST_IDLE,      // ready for a byte
    ST_EXEC,      // classify, arithmetic, start division
    ST_DIV_WAIT,  // divider running
    ST_APPLY,     // pop two, push the result
    ST_FINISH     // end of a byte; on the last one, hand over the result word
  } state_t;

  state_t              state;
  logic [COUNT_W-1:0]  count;
  logic                underflow_flag;
  logic                overflow_flag;
  logic                divide_zero_flag;

  logic [SYMBOL_W-1:0] sym;
  logic                last;
  logic [WORD_W-1:0]   left_op;
  logic [WORD_W-1:0]   right_op;
  logic [WORD_W-1:0]   result_word;

  logic                out_valid;
  logic                out_load;
  logic [WORD_W-1:0]   out_value;
  logic                out_underflow;
  logic                out_overflow;
  logic                out_divide_zero;

  // cell row; two spare slots past the bottom read as zero
  logic [WORD_W-1:0]   cell_value [STACK_DEPTH+2];
  cell_op_t            cell_op;
  logic [WORD_W-1:0]   cell_in;

  logic                sym_digit;
  logic                sym_arith;
  logic                sym_div;
  logic                stack_full;
  logic [COUNT_W-1:0]  count_after_pops;
  logic                div_start;
  logic                div_done;
  logic [WORD_W-1:0]   div_quotient;

  assign sym_digit  = is_digit(sym);
  assign sym_arith  = (sym == CHAR_PLUS) || (sym == CHAR_MINUS) || (sym == CHAR_STAR);
  assign sym_div    = (sym == CHAR_SLASH);
  assign stack_full = (count >= COUNT_W'(STACK_DEPTH));

  // an empty pop removes nothing, so two pops never go below zero
  assign count_after_pops = (count >= COUNT_W'(2)) ? (count - COUNT_W'(2)) : '0;

  assign div_start = (state == ST_EXEC) && !sym_digit && sym_div && (right_op != '0);

  // result word enters the output register this cycle
  assign out_load = (state == ST_FINISH) && last && (!out_valid || result.ready);

  // --- stack cells --------------------------------------------------------
  // cell_in is the word that enters at the top on a push or replace
  always_comb begin
    cell_op = CELL_HOLD;
    cell_in = result_word;
    unique case (state)
      ST_EXEC: begin
        if (sym_digit) begin
          if (!stack_full) begin
            cell_op = CELL_PUSH;
            cell_in = WORD_W'(sym - CHAR_ZERO);
          end
        end else if (!sym_arith && !sym_div) begin
          cell_op = CELL_POP2;
        end
      end
      ST_APPLY: cell_op = CELL_POP_REPLACE;
      ST_IDLE, ST_DIV_WAIT, ST_FINISH: cell_op = CELL_HOLD;
      default: cell_op = CELL_HOLD;
    endcase
  end

  assign cell_value[STACK_DEPTH]   = '0;
  assign cell_value[STACK_DEPTH+1] = '0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] push_src;
    logic [WORD_W-1:0] replace_src;

    if (i == 0) begin : g_top
      assign push_src    = cell_in;
      assign replace_src = cell_in;
    end else begin : g_body
      assign push_src    = cell_value[i-1];
      assign replace_src = cell_value[i+1];
    end

    ppe_stack_cell u_cell (
      .clk           (clk),
      .op            (cell_op),
      .push_value    (push_src),
      .replace_value (replace_src),
      .pop2_value    (cell_value[i+2]),
      .value         (cell_value[i])
    );
  end

  // --- divider ------------------------------------------------------------
  ppe_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left_op),
    .divisor  (right_op),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // --- control ------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      count            <= '0;
      underflow_flag   <= 1'b0;
      overflow_flag    <= 1'b0;
      divide_zero_flag <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (result.ready && !out_load) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            sym      <= item.symbol;
            last     <= item.is_last;
            // first pop is the right operand; empty pops read all ones
            right_op <= (count != '0) ? cell_value[0] : EMPTY_WORD;
            left_op  <= (count >= COUNT_W'(2)) ? cell_value[1] : EMPTY_WORD;
            if (!is_digit(item.symbol) && (count < COUNT_W'(2))) underflow_flag <= 1'b1;
            state    <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          if (sym_digit) begin
            if (!stack_full) count <= count + 1'b1;
            else             overflow_flag <= 1'b1;
            state <= ST_FINISH;
          end else if (sym_arith) begin
            priority if (sym == CHAR_PLUS)  result_word <= left_op + right_op;
            else if (sym == CHAR_MINUS)     result_word <= left_op - right_op;
            else                            result_word <= left_op * right_op;
            state <= ST_APPLY;
          end else if (sym_div) begin
            if (right_op == '0) begin
              result_word      <= '0;
              divide_zero_flag <= 1'b1;
              state            <= ST_APPLY;
            end else begin
              state <= ST_DIV_WAIT;
            end
          end else begin
            count <= count_after_pops;
            state <= ST_FINISH;
          end
        end

        ST_DIV_WAIT: begin
          if (div_done) begin
            result_word <= div_quotient;
            state       <= ST_APPLY;
          end
        end

        ST_APPLY: begin
          count <= count_after_pops + 1'b1;
          state <= ST_FINISH;
        end

        ST_FINISH: begin
          if (!last) begin
            state <= ST_IDLE;
          end else if (out_load) begin
            out_valid        <= 1'b1;
            out_value        <= (count == '0) ? EMPTY_WORD : cell_value[0];
            out_underflow    <= underflow_flag;
            out_overflow     <= overflow_flag;
            out_divide_zero  <= divide_zero_flag;
            count            <= '0;
            underflow_flag   <= 1'b0;
            overflow_flag    <= 1'b0;
            divide_zero_flag <= 1'b0;
            state            <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign item.ready                 = (state == ST_IDLE);
  assign result.valid               = out_valid;
  assign result.result_value        = out_value;
  assign result.underflow_seen      = out_underflow;
  assign result.overflow_seen       = out_overflow;
  assign result.divide_by_zero_seen = out_divide_zero;

endmodule

>>> hdl/ppe_stack_cell.sv
// ----------------------------------------------------------------------------
// ppe_stack_cell: one entry of the shifting value stack
// Takes a nearby or new word, or holds, as the shared operation says.
// ----------------------------------------------------------------------------
module ppe_stack_cell
  import ppe_pkg::*;
(
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [WORD_W-1:0] push_value,
  input  logic [WORD_W-1:0] replace_value,
  input  logic [WORD_W-1:0] pop2_value,
  output logic [WORD_W-1:0] value
);

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD:        value <= value;
      CELL_PUSH:        value <= push_value;
      CELL_POP_REPLACE: value <= replace_value;
      CELL_POP2:        value <= pop2_value;
    endcase
  end

endmodule

>>> hdl/ppe_divider.sv
// ----------------------------------------------------------------------------
// ppe_divider: iterative signed divider, truncating toward zero
// Restoring division on magnitudes, one quotient bit a cycle, then sign fix.
// ----------------------------------------------------------------------------
module ppe_divider
  import ppe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_FIX} div_state_t;

  div_state_t           state;
  logic [DIV_CNT_W-1:0] step;
  logic                 negate;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    quo;
  logic [WORD_W-1:0]    mag_d;
  logic [WORD_W:0]      rem_shift;
  logic [WORD_W:0]      diff;

  assign rem_shift = {rem, quo[WORD_W-1]};
  assign diff      = rem_shift - {1'b0, mag_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        DIV_IDLE: begin
          if (start) begin
            negate <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            quo    <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            mag_d  <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
            rem    <= '0;
            step   <= '0;
            state  <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          if (!diff[WORD_W]) begin
            rem <= diff[WORD_W-1:0];
            quo <= {quo[WORD_W-2:0], 1'b1};
          end else begin
            rem <= rem_shift[WORD_W-1:0];
            quo <= {quo[WORD_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == '1) state <= DIV_FIX;
        end
        DIV_FIX: begin
          quotient <= negate ? (~quo + 1'b1) : quo;
          done     <= 1'b1;
          state    <= DIV_IDLE;
        end
        default: state <= DIV_IDLE;
      endcase
    end
  end

endmodule
